/* rtl/tkda_pkg.sv */
// ----------------------------------------------------------------------------
// tkda_pkg
// Shared types and constants for the three-key debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package tkda_pkg;

    localparam int unsigned KEY_COUNT  = 3;
    localparam int unsigned HIST_W     = 3;
    localparam int unsigned TIMER_W    = 16;

    localparam logic [TIMER_W-1:0] PERIOD_RESET  = 16'd2000;
    localparam logic [HIST_W-1:0]  HIST_RELEASED = 3'b111;
    localparam logic [HIST_W-1:0]  HIST_ZEROS    = 3'b000;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_PRESSED_LEVEL = 1'b0,
        REG_REPEAT_PERIOD = 1'b1
    } cfg_reg_t;

    // Per-key debounce state
    typedef struct packed {
        logic [HIST_W-1:0] history;
        logic              stable;
        logic              flag;
    } key_state_t;

    // One result word
    typedef struct packed {
        logic [KEY_COUNT-1:0] answer;
        logic [KEY_COUNT-1:0] pending;
    } result_t;

endpackage

/* rtl/tkda_key_step.sv */
// ----------------------------------------------------------------------------
// tkda_key_step
// Debounce and repeat update of one key against the shared repeat timer.
// ----------------------------------------------------------------------------
module tkda_key_step (
    input  logic                             tick,
    input  logic                             level,
    input  logic                             pressed_level,
    input  logic [tkda_pkg::TIMER_W-1:0]     repeat_period,
    input  tkda_pkg::key_state_t             key_in,
    input  logic [tkda_pkg::TIMER_W-1:0]     timer_in,
    output tkda_pkg::key_state_t             key_out,
    output logic [tkda_pkg::TIMER_W-1:0]     timer_out
);

    logic [tkda_pkg::HIST_W-1:0]  hist_new;
    logic                         settled;
    logic [tkda_pkg::TIMER_W-1:0] timer_dec;

    assign hist_new  = {key_in.history[tkda_pkg::HIST_W-2:0], level};
    assign settled   = (hist_new == tkda_pkg::HIST_ZEROS) ||
                       (hist_new == tkda_pkg::HIST_RELEASED);
    assign timer_dec = timer_in - tkda_pkg::TIMER_W'(1);

    always_comb
    begin
        key_out   = key_in;
        timer_out = timer_in;
        if (tick)
        begin
            key_out.history = hist_new;
            if (settled)
            begin
                if (key_in.stable != level)
                begin
                    // A newly accepted level; a press restarts the repeat delay.
                    key_out.stable = level;
                    if (level == pressed_level)
                    begin
                        key_out.flag = 1'b1;
                        timer_out    = repeat_period;
                    end
                end
                else if (timer_dec == '0)
                begin
                    if (level == pressed_level)
                    begin
                        key_out.flag = 1'b1;
                    end
                    timer_out = repeat_period;
                end
                else
                begin
                    timer_out = timer_dec;
                end
            end
        end
    end

endmodule

/* rtl/three_key_debounce_autorepeat_top.sv */
// ----------------------------------------------------------------------------
// three_key_debounce_autorepeat_top
// Three-key debouncer with sticky press flags and shared long-press repeat.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while in_stall is low and
// returns one result word for each from its output register. Take requests are
// served first, then the three sampled levels pass through three chained key
// update stages that share one 16-bit repeat timer, all combinationally. An
// output register with a one-word skid stage lets a new word be accepted while
// a result still waits, so the sustained rate is one word per cycle whenever
// the output side is not stalled.
module three_key_debounce_autorepeat_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        tick,
    input  logic        level_select,
    input  logic        level_up,
    input  logic        level_set,
    input  logic        take_select,
    input  logic        take_up,
    input  logic        take_set,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        answer_select,
    output logic        answer_up,
    output logic        answer_set,
    output logic        pending_select,
    output logic        pending_up,
    output logic        pending_set
);

    localparam int unsigned N = tkda_pkg::KEY_COUNT;

    logic                         pressed_level_reg;
    logic [tkda_pkg::TIMER_W-1:0] repeat_period_reg;

    tkda_pkg::key_state_t         key_reg   [N];
    tkda_pkg::key_state_t         key_taken [N];
    tkda_pkg::key_state_t         key_next  [N];
    logic [tkda_pkg::TIMER_W-1:0] timer_reg;
    logic [tkda_pkg::TIMER_W-1:0] timer_chain [N+1];

    logic [N-1:0] level_vec;
    logic [N-1:0] take_vec;

    tkda_pkg::result_t result_new;
    tkda_pkg::result_t main_reg;
    tkda_pkg::result_t skid_reg;
    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic              accept_in;
    logic              out_fire;

    assign level_vec = {level_set, level_up, level_select};
    assign take_vec  = {take_set, take_up, take_select};

    assign in_stall  = skid_valid_reg;
    assign accept_in = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_fire  = main_valid_reg && !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_level_reg <= 1'b0;
            repeat_period_reg <= tkda_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tkda_pkg::cfg_reg_t'(cfg_index))
                tkda_pkg::REG_PRESSED_LEVEL: pressed_level_reg <= cfg_data[0];
                tkda_pkg::REG_REPEAT_PERIOD:
                    repeat_period_reg <= cfg_data[tkda_pkg::TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // Take requests read the flags before this word's tick update.
    assign timer_chain[0] = timer_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_key
        always_comb
        begin
            key_taken[k]      = key_reg[k];
            key_taken[k].flag = key_reg[k].flag && !take_vec[k];
            result_new.answer[k]  = key_reg[k].flag && take_vec[k];
            result_new.pending[k] = key_next[k].flag;
        end

        tkda_key_step u_step (
            .tick          (tick),
            .level         (level_vec[k]),
            .pressed_level (pressed_level_reg),
            .repeat_period (repeat_period_reg),
            .key_in        (key_taken[k]),
            .timer_in      (timer_chain[k]),
            .key_out       (key_next[k]),
            .timer_out     (timer_chain[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                key_reg[k].history <= tkda_pkg::HIST_RELEASED;
                key_reg[k].stable  <= 1'b1;
                key_reg[k].flag    <= 1'b0;
            end
            else if (accept_in)
            begin
                key_reg[k] <= key_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= tkda_pkg::PERIOD_RESET;
        end
        else if (accept_in)
        begin
            timer_reg <= timer_chain[N];
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= accept_in;
            end
        end
        else if (accept_in)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (accept_in)
            begin
                main_reg <= result_new;
            end
        end
        else if (accept_in)
        begin
            skid_reg <= result_new;
        end
    end

    assign answer_select  = main_reg.answer[0];
    assign answer_up      = main_reg.answer[1];
    assign answer_set     = main_reg.answer[2];
    assign pending_select = main_reg.pending[0];
    assign pending_up     = main_reg.pending[1];
    assign pending_set    = main_reg.pending[2];

    // The skid stage only fills behind a held output word.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word held without an output word");

    // Key state moves only when a word is accepted.
    a_keys_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept_in |=> ($stable(key_reg[0]) && $stable(key_reg[1]) &&
                        $stable(key_reg[2]) && $stable(timer_reg)))
        else $error("key state changed without an accepted word");

    // Without a sample tick the repeat timer stays put.
    a_timer_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && !tick) |=> $stable(timer_reg))
        else $error("repeat timer moved on a word without a tick");

endmodule

/* tb/three_key_debounce_autorepeat_top_test.sv */
// ----------------------------------------------------------------------------
// three_key_debounce_autorepeat_top_test
// Self-checking testbench for the three-key debouncer with auto-repeat.
// ----------------------------------------------------------------------------
// A short directed table comes first. It covers the reset state, settling
// after three equal samples, take requests, take and press in the same
// word, the repeat period at one and at zero, and the pressed level changed
// away from its reset value. Random phases follow under several register
// settings. The random key levels hold for a while and bounce now and then,
// so keys really settle and the repeat timer runs. An internal predictor
// works out each result word, and every accepted output word is compared
// with the oldest prediction. The sender runs in bursts with gaps between
// them, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module three_key_debounce_autorepeat_top_test;

    // Bit 0 is the select key, bit 1 the up key and bit 2 the set key.
    typedef struct packed {
        logic                           tick;
        logic [tkda_pkg::KEY_COUNT-1:0] level;
        logic [tkda_pkg::KEY_COUNT-1:0] take;
    } key_word_t;

    typedef enum logic {
        ROW_WORD,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        tkda_pkg::cfg_reg_t  cfg_sel;
        logic [15:0]         cfg_value;
        key_word_t           word;
        logic                typed;
        tkda_pkg::result_t   typed_result;
    } row_t;

    localparam int RANDOM_PHASES     = 6;
    localparam int WORDS_PER_PHASE   = 100;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    key_word_t   in_word;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        answer_select;
    logic        answer_up;
    logic        answer_set;
    logic        pending_select;
    logic        pending_up;
    logic        pending_set;

    // Predictor state and register copies
    logic [tkda_pkg::HIST_W-1:0]    key_hist [tkda_pkg::KEY_COUNT];
    logic [tkda_pkg::KEY_COUNT-1:0] key_stable;
    logic [tkda_pkg::KEY_COUNT-1:0] press_flag;
    logic [tkda_pkg::TIMER_W-1:0]   repeat_count;
    logic                           cfg_pressed;
    logic [tkda_pkg::TIMER_W-1:0]   cfg_period;

    tkda_pkg::result_t              expected_words [$];
    row_t                           directed_rows [$];
    int                             failures;
    int                             words_checked;
    int                             words_sent;
    int                             settings_used;
    int                             burst_left;
    int                             stall_left = 0;
    int                             stall_mode = 0;
    logic [tkda_pkg::KEY_COUNT-1:0] key_target;

    three_key_debounce_autorepeat_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .tick           (in_word.tick),
        .level_select   (in_word.level[0]),
        .level_up       (in_word.level[1]),
        .level_set      (in_word.level[2]),
        .take_select    (in_word.take[0]),
        .take_up        (in_word.take[1]),
        .take_set       (in_word.take[2]),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .answer_select  (answer_select),
        .answer_up      (answer_up),
        .answer_set     (answer_set),
        .pending_select (pending_select),
        .pending_up     (pending_up),
        .pending_set    (pending_set)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Takes are served first, then a tick samples the keys in order.
    function automatic tkda_pkg::result_t debounce_step(input key_word_t w);
        tkda_pkg::result_t           r;
        logic [tkda_pkg::HIST_W-1:0] h;
        r = '0;
        for (int k = 0; k < tkda_pkg::KEY_COUNT; k++)
        begin
            if (w.take[k])
            begin
                r.answer[k]   = press_flag[k];
                press_flag[k] = 1'b0;
            end
        end
        if (w.tick)
        begin
            for (int k = 0; k < tkda_pkg::KEY_COUNT; k++)
            begin
                h           = {key_hist[k][tkda_pkg::HIST_W-2:0], w.level[k]};
                key_hist[k] = h;
                if (h == tkda_pkg::HIST_RELEASED || h == tkda_pkg::HIST_ZEROS)
                begin
                    if (key_stable[k] != w.level[k])
                    begin
                        key_stable[k] = w.level[k];
                        if (w.level[k] == cfg_pressed)
                        begin
                            press_flag[k] = 1'b1;
                            repeat_count  = cfg_period;
                        end
                    end
                    else
                    begin
                        repeat_count = repeat_count - 1'b1;
                        if (repeat_count == '0)
                        begin
                            if (w.level[k] == cfg_pressed)
                                press_flag[k] = 1'b1;
                            repeat_count = cfg_period;
                        end
                    end
                end
            end
        end
        r.pending = press_flag;
        return r;
    endfunction

    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(1, 6);
    endfunction

    task automatic add_word(input logic tk, input logic [2:0] lv, input logic [2:0] tq,
                            input logic typed, input logic [2:0] ans,
                            input logic [2:0] pend);
        row_t r;
        r.kind         = ROW_WORD;
        r.cfg_sel      = tkda_pkg::REG_PRESSED_LEVEL;
        r.cfg_value    = '0;
        r.word         = '{tick: tk, level: lv, take: tq};
        r.typed        = typed;
        r.typed_result = '{answer: ans, pending: pend};
        directed_rows.push_back(r);
    endtask

    task automatic add_write(input tkda_pkg::cfg_reg_t sel, input logic [15:0] value);
        row_t r;
        r.kind         = ROW_WRITE;
        r.cfg_sel      = sel;
        r.cfg_value    = value;
        r.word         = '0;
        r.typed        = 1'b0;
        r.typed_result = '0;
        directed_rows.push_back(r);
    endtask

    // Starts right after an acceptance edge, or after a flush, and returns at
    // the edge at which the word is accepted.
    task automatic drive_word(input key_word_t w, input int gap, input logic typed,
                              input tkda_pkg::result_t typed_result);
        tkda_pkg::result_t predicted;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        predicted = debounce_step(w);
        expected_words.push_back(typed ? typed_result : predicted);
        words_sent++;
    endtask

    // Stops sending, waits for every result word, then lets the block settle.
    task automatic flush_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Called at a falling edge with the block idle; returns at a later falling
    // edge at which nothing has been driven yet.
    task automatic write_reg(input tkda_pkg::cfg_reg_t sel, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == tkda_pkg::REG_PRESSED_LEVEL)
            cfg_pressed = value[0];
        else
            cfg_period = value;
        @(negedge clk);
    endtask

    // Key levels mostly hold and sometimes bounce; a few words are pure noise.
    function automatic key_word_t random_word();
        key_word_t w;
        w.tick = ($urandom_range(0, 99) < 85);
        for (int k = 0; k < tkda_pkg::KEY_COUNT; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                key_target[k] = ~key_target[k];
            w.level[k] = key_target[k] ^ ($urandom_range(0, 15) == 0);
            w.take[k]  = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 9) == 0)
            w.level = 3'($urandom_range(0, 7));
        return w;
    endfunction

    // Receiver stall patterns: none, random, periodic and long stretches.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= (stall_left % 3 == 0);
            default: out_stall <= (stall_left % 8 < 5);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        tkda_pkg::result_t got;
        tkda_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.answer  = {answer_set, answer_up, answer_select};
            got.pending = {pending_set, pending_up, pending_select};
            if (expected_words.size() == 0)
            begin
                $error("result word with no prediction waiting: answer %b pending %b",
                       got.answer, got.pending);
                failures++;
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (got.answer[0] !== want.answer[0])
                begin
                    $error("answer_select expected %b actual %b", want.answer[0], got.answer[0]);
                    failures++;
                end
                if (got.answer[1] !== want.answer[1])
                begin
                    $error("answer_up expected %b actual %b", want.answer[1], got.answer[1]);
                    failures++;
                end
                if (got.answer[2] !== want.answer[2])
                begin
                    $error("answer_set expected %b actual %b", want.answer[2], got.answer[2]);
                    failures++;
                end
                if (got.pending[0] !== want.pending[0])
                begin
                    $error("pending_select expected %b actual %b",
                           want.pending[0], got.pending[0]);
                    failures++;
                end
                if (got.pending[1] !== want.pending[1])
                begin
                    $error("pending_up expected %b actual %b", want.pending[1], got.pending[1]);
                    failures++;
                end
                if (got.pending[2] !== want.pending[2])
                begin
                    $error("pending_set expected %b actual %b", want.pending[2], got.pending[2]);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic        phase_pressed [RANDOM_PHASES];
        logic [15:0] phase_period  [RANDOM_PHASES];
        phase_pressed = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_period  = '{16'd1, 16'd3, 16'd0, 16'd65535, 16'd2, 16'd7};

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_word       = '0;
        failures      = 0;
        words_checked = 0;
        words_sent    = 0;
        settings_used = 1;
        burst_left    = 0;
        key_target    = '1;

        for (int k = 0; k < tkda_pkg::KEY_COUNT; k++)
            key_hist[k] = tkda_pkg::HIST_RELEASED;
        key_stable   = '1;
        press_flag   = '0;
        repeat_count = tkda_pkg::PERIOD_RESET;
        cfg_pressed  = 1'b0;
        cfg_period   = tkda_pkg::PERIOD_RESET;

        // Level and take columns read {set, up, select}.
        // Reset levels are ones even when ones mean pressed: no press is seen.
        add_write(tkda_pkg::REG_PRESSED_LEVEL, 16'd1);
        add_word(1'b1, 3'b111, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b111, 3'b111, 1'b0, 3'b000, 3'b000);
        add_write(tkda_pkg::REG_PRESSED_LEVEL, 16'd0);
        // No tick: nothing is sampled.
        add_word(1'b0, 3'b000, 3'b111, 1'b1, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b1, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b1, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b1, 3'b000, 3'b111);
        add_word(1'b0, 3'b111, 3'b111, 1'b1, 3'b111, 3'b000);
        add_word(1'b1, 3'b000, 3'b111, 1'b1, 3'b000, 3'b000);
        // Select and set bounce and so stay unsettled for a while.
        add_word(1'b1, 3'b101, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b111, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b111, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b0, 3'b000, 3'b000);
        // Take and a new press in one word.
        add_word(1'b1, 3'b000, 3'b111, 1'b0, 3'b000, 3'b000);
        add_write(tkda_pkg::REG_REPEAT_PERIOD, 16'd1);
        add_word(1'b1, 3'b000, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b111, 1'b0, 3'b000, 3'b000);
        // A zero period reloads to zero and then wraps to the top.
        add_write(tkda_pkg::REG_REPEAT_PERIOD, 16'd0);
        add_word(1'b1, 3'b111, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b111, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b111, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b1, 3'b000, 3'b000, 1'b0, 3'b000, 3'b000);
        add_word(1'b0, 3'b010, 3'b111, 1'b0, 3'b000, 3'b000);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                flush_block();
                write_reg(directed_rows[i].cfg_sel, directed_rows[i].cfg_value);
                settings_used++;
            end
            else
            begin
                drive_word(directed_rows[i].word, next_gap(), directed_rows[i].typed,
                           directed_rows[i].typed_result);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            flush_block();
            write_reg(tkda_pkg::REG_PRESSED_LEVEL, {15'd0, phase_pressed[p]});
            write_reg(tkda_pkg::REG_REPEAT_PERIOD, phase_period[p]);
            settings_used++;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                drive_word(random_word(), next_gap(), 1'b0, '0);
        end
        flush_block();

        $display("Sent %0d input words under %0d register settings, checked %0d result words.",
                 words_sent, settings_used, words_checked);
        $display("Covered settling, bouncing, take requests and periods of 0, 1 and 65535.");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
